// ===== hw/rtl/ffrp_pkg.sv =====
// shared types, codes and constants for the sequence record parser
`default_nettype none
package ffrp_pkg;

  localparam int LINE_COUNT_BITS = 24;
  localparam int ERR_LINE_BITS   = 24;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LINE_COUNT_BITS-1:0] LINE_CNT_MAX = '1;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;

  typedef enum logic [1:0] {
    MODE_DETECT = 2'd0,
    MODE_FASTA  = 2'd1,
    MODE_FASTQ  = 2'd2,
    MODE_BARE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FMT_FASTA = 2'd0,
    FMT_FASTQ = 2'd1,
    FMT_BARE  = 2'd2
  } fmt_t;

  typedef enum logic [1:0] {
    ROLE_HEADER = 2'd0,
    ROLE_SEQ    = 2'd1,
    ROLE_PLUS   = 2'd2,
    ROLE_QUAL   = 2'd3
  } role_t;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_HEADER = 3'd1,
    KIND_SEQ    = 3'd2,
    KIND_DROP   = 3'd3,
    KIND_STRIP  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_MARKER = 3'd1,
    ERR_NO_SEQ     = 3'd2,
    ERR_NO_PLUS    = 3'd3,
    ERR_NO_QUAL    = 3'd4,
    ERR_BAD_HEADER = 3'd5
  } err_t;

  typedef struct packed {
    logic                     data_valid;
    logic [7:0]               char_out;
    logic                     is_header;
    logic                     in_identifier;
    logic                     record_start;
    logic                     stream_end;
    fmt_t                     format_found;
    err_t                     error_code;
    logic [ERR_LINE_BITS-1:0] error_line;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ffrp_front.sv =====
// front end: line tracking, format detection, byte classification and error checks
`default_nettype none
module ffrp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_wr_data,
  input  wire logic              take,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  output logic                   push,
  output ffrp_pkg::result_t      push_res
);

  ffrp_pkg::mode_t mode_r;
  ffrp_pkg::fmt_t  fmt_r, fmt_nxt;
  ffrp_pkg::role_t role_r, role_nxt;
  ffrp_pkg::kind_t kind_r, kind_nxt;
  ffrp_pkg::err_t  err_r, err_nxt;
  logic first_seen_r, first_seen_nxt;
  logic at_start_r, at_start_nxt;
  logic ident_r, ident_nxt;
  logic done_r, done_nxt;
  logic [ffrp_pkg::LINE_COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic had_err, first_byte, opens, first_line, emit;
  logic dv, hdr, ident_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= ffrp_pkg::MODE_DETECT;
      fmt_r        <= ffrp_pkg::FMT_FASTA;
      role_r       <= ffrp_pkg::ROLE_HEADER;
      kind_r       <= ffrp_pkg::KIND_NONE;
      err_r        <= ffrp_pkg::ERR_NONE;
      first_seen_r <= 1'b0;
      at_start_r   <= 1'b1;
      ident_r      <= 1'b0;
      done_r       <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= ffrp_pkg::mode_t'(cfg_wr_data);
      end
      fmt_r        <= fmt_nxt;
      role_r       <= role_nxt;
      kind_r       <= kind_nxt;
      err_r        <= err_nxt;
      first_seen_r <= first_seen_nxt;
      at_start_r   <= at_start_nxt;
      ident_r      <= ident_nxt;
      done_r       <= done_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_comb begin
    fmt_nxt        = fmt_r;
    role_nxt       = role_r;
    kind_nxt       = kind_r;
    err_nxt        = err_r;
    first_seen_nxt = first_seen_r;
    at_start_nxt   = at_start_r;
    ident_nxt      = ident_r;
    done_nxt       = done_r;
    cnt_nxt        = cnt_r;
    had_err        = (err_r != ffrp_pkg::ERR_NONE);
    first_byte     = 1'b0;
    opens          = 1'b0;
    first_line     = 1'b0;
    emit           = 1'b0;
    dv             = 1'b0;
    hdr            = 1'b0;
    ident_o        = 1'b0;

    if (take && !done_r) begin
      if (!had_err) begin
        if (at_start_r && (cnt_r != ffrp_pkg::LINE_CNT_MAX)) begin
          cnt_nxt = cnt_r + ffrp_pkg::LINE_COUNT_BITS'(1);
        end
        if (in_byte == ffrp_pkg::CH_LF) begin
          if (!at_start_r) begin
            if (fmt_nxt == ffrp_pkg::FMT_FASTQ) begin
              role_nxt = ffrp_pkg::role_t'(role_nxt + 2'd1);
            end
            ident_nxt = 1'b0;
            kind_nxt  = ffrp_pkg::KIND_NONE;
          end
          at_start_nxt = 1'b1;
        end else begin
          first_byte = at_start_r;
          if (first_byte) begin
            at_start_nxt = 1'b0;
            // first non-empty line fixes the format
            if (!first_seen_r) begin
              first_seen_nxt = 1'b1;
              first_line     = 1'b1;
              role_nxt       = ffrp_pkg::ROLE_HEADER;
              case (mode_r)
                ffrp_pkg::MODE_DETECT: begin
                  fmt_nxt = (in_byte == ffrp_pkg::CH_GT) ? ffrp_pkg::FMT_FASTA :
                            (in_byte == ffrp_pkg::CH_AT) ? ffrp_pkg::FMT_FASTQ :
                                                           ffrp_pkg::FMT_BARE;
                end
                ffrp_pkg::MODE_FASTA: begin
                  fmt_nxt = ffrp_pkg::FMT_FASTA;
                  if (in_byte != ffrp_pkg::CH_GT) err_nxt = ffrp_pkg::ERR_BAD_MARKER;
                end
                ffrp_pkg::MODE_FASTQ: begin
                  fmt_nxt = ffrp_pkg::FMT_FASTQ;
                  if (in_byte != ffrp_pkg::CH_AT) err_nxt = ffrp_pkg::ERR_BAD_MARKER;
                end
                default: begin
                  fmt_nxt = ffrp_pkg::FMT_BARE;
                end
              endcase
            end
            if (err_nxt == ffrp_pkg::ERR_NONE) begin
              case (fmt_nxt)
                ffrp_pkg::FMT_FASTA: begin
                  if (in_byte == ffrp_pkg::CH_GT) begin
                    kind_nxt = ffrp_pkg::KIND_HEADER;
                    opens    = 1'b1;
                  end else begin
                    kind_nxt = ffrp_pkg::KIND_SEQ;
                  end
                end
                ffrp_pkg::FMT_FASTQ: begin
                  case (role_nxt)
                    ffrp_pkg::ROLE_HEADER: begin
                      if (in_byte == ffrp_pkg::CH_AT) begin
                        kind_nxt = ffrp_pkg::KIND_HEADER;
                        opens    = 1'b1;
                      end else begin
                        err_nxt = ffrp_pkg::ERR_BAD_HEADER;
                      end
                    end
                    ffrp_pkg::ROLE_SEQ: kind_nxt = ffrp_pkg::KIND_SEQ;
                    ffrp_pkg::ROLE_PLUS: begin
                      if (in_byte == ffrp_pkg::CH_PLUS) kind_nxt = ffrp_pkg::KIND_DROP;
                      else err_nxt = ffrp_pkg::ERR_NO_PLUS;
                    end
                    default: kind_nxt = ffrp_pkg::KIND_DROP;
                  endcase
                end
                default: begin
                  kind_nxt = first_line ? ffrp_pkg::KIND_SEQ : ffrp_pkg::KIND_STRIP;
                  opens    = first_line;
                end
              endcase
            end
          end
          if (err_nxt == ffrp_pkg::ERR_NONE) begin
            case (kind_nxt)
              ffrp_pkg::KIND_HEADER: begin
                dv  = 1'b1;
                hdr = 1'b1;
                if (first_byte) begin
                  ident_nxt = 1'b1;
                end else if (ident_r) begin
                  if (ffrp_pkg::is_ws(in_byte)) ident_nxt = 1'b0;
                  else ident_o = 1'b1;
                end
              end
              ffrp_pkg::KIND_SEQ:   dv = 1'b1;
              ffrp_pkg::KIND_STRIP: dv = (in_byte != ffrp_pkg::CH_SPACE);
              default:              dv = 1'b0;
            endcase
            emit = dv;
          end
        end
      end

      if (in_last) begin
        if ((err_nxt == ffrp_pkg::ERR_NONE) && !at_start_nxt) begin
          if (fmt_nxt == ffrp_pkg::FMT_FASTQ) begin
            role_nxt = ffrp_pkg::role_t'(role_nxt + 2'd1);
          end
          ident_nxt = 1'b0;
          kind_nxt  = ffrp_pkg::KIND_NONE;
        end
        at_start_nxt = 1'b1;
        // truncated record at end of stream
        if ((err_nxt == ffrp_pkg::ERR_NONE) && first_seen_nxt &&
            (fmt_nxt == ffrp_pkg::FMT_FASTQ)) begin
          case (role_nxt)
            ffrp_pkg::ROLE_SEQ:  err_nxt = ffrp_pkg::ERR_NO_SEQ;
            ffrp_pkg::ROLE_PLUS: err_nxt = ffrp_pkg::ERR_NO_PLUS;
            ffrp_pkg::ROLE_QUAL: err_nxt = ffrp_pkg::ERR_NO_QUAL;
            default:             err_nxt = err_nxt;
          endcase
        end
        done_nxt = 1'b1;
        emit     = 1'b1;
      end

      if (!had_err && (err_nxt != ffrp_pkg::ERR_NONE)) begin
        emit = 1'b1;
      end
    end
  end

  assign push = emit;

  always_comb begin
    push_res.data_valid    = dv;
    push_res.char_out      = dv ? in_byte : 8'd0;
    push_res.is_header     = hdr;
    push_res.in_identifier = ident_o;
    push_res.record_start  = dv & opens;
    push_res.stream_end    = take & !done_r & in_last;
    push_res.format_found  = fmt_nxt;
    push_res.error_code    = err_nxt;
    push_res.error_line    = (err_nxt != ffrp_pkg::ERR_NONE) ?
                             ffrp_pkg::ERR_LINE_BITS'(cnt_nxt) : '0;
  end

`ifndef NO_ASSERTIONS
  a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !push)
    else $error("result produced after end of stream");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ffrp_pkg::ERR_NONE) |=> (err_r == $past(err_r)) && (cnt_r == $past(cnt_r)))
    else $error("error code or line count changed after an error");
  a_line_only_with_err: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (push_res.error_code == ffrp_pkg::ERR_NONE)) |-> (push_res.error_line == '0))
    else $error("error line reported without an error");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/ffrp_queue.sv =====
// small result queue between the parser front end and the output stage
`default_nettype none
module ffrp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire ffrp_pkg::result_t  push_data,
  input  wire logic               pop,
  output ffrp_pkg::result_t       head,
  output ffrp_pkg::q_stat_t       stat
);

  ffrp_pkg::result_t mem_r [ffrp_pkg::QUEUE_DEPTH];
  logic [ffrp_pkg::QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [ffrp_pkg::QCNT_BITS-1:0] cnt_r;
  logic do_push, do_pop;

  assign stat.full  = (cnt_r == ffrp_pkg::QCNT_BITS'(ffrp_pkg::QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push & !stat.full;
  assign do_pop     = pop & !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  function automatic logic [ffrp_pkg::QPTR_BITS-1:0] ptr_inc(
    input logic [ffrp_pkg::QPTR_BITS-1:0] p);
    return (p == ffrp_pkg::QPTR_BITS'(ffrp_pkg::QUEUE_DEPTH - 1)) ? '0 :
           p + ffrp_pkg::QPTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + ffrp_pkg::QCNT_BITS'(1);
        2'b01:   cnt_r <= cnt_r - ffrp_pkg::QCNT_BITS'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("word pushed into a full queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ffrp_pkg::QCNT_BITS'(ffrp_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> (wr_ptr_r == rd_ptr_r))
    else $error("pointers differ on an empty queue");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/ffrp_back.sv =====
// output stage: pulls results from the queue into the result register and packs the bus
`default_nettype none
module ffrp_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ffrp_pkg::q_stat_t  stat,
  input  wire ffrp_pkg::result_t  head,
  output logic                    pop,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [39:0]             out_tdata,
  output logic [3:0]              out_tuser,
  output logic                    out_tlast
);

  logic              valid_r;
  ffrp_pkg::result_t res_r;

  assign pop = !stat.empty && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= head;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = res_r.stream_end;
  assign out_tuser  = {res_r.record_start, res_r.in_identifier, res_r.is_header,
                       res_r.data_valid};
  assign out_tdata  = {3'd0, res_r.error_line, res_r.error_code, res_r.format_found,
                       res_r.char_out};

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from an empty queue");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_tready) |-> !pop)
    else $error("held word would be overwritten");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r)
    else $error("popped word not presented");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/fasta_fastq_record_parser.sv =====
// path: the result word of an accepted byte goes into the queue, then into the output register at out_*
// throughput: one byte per cycle; a four-word queue decouples parser and output register
// in_tready drops only while that queue is full; bytes causing no result write nothing to it
// reset: synchronous active-low rst_n clears parser state, format mode, queue and output
// configuration format_mode resets to detect and is sampled at the first non-empty line
`default_nettype none
module fasta_fastq_record_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,  // format_mode
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // byte_value
  input  wire logic        in_tlast,     // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // char_out[7:0], format_found[9:8], error_code[12:10], error_line[36:13], zero[39:37]
  output logic [39:0]      out_tdata,
  // data_valid[0], is_header[1], in_identifier[2], record_start[3]
  output logic [3:0]       out_tuser,
  output logic             out_tlast     // stream_end
);

  ffrp_pkg::result_t push_res, head;
  ffrp_pkg::q_stat_t stat;
  logic take, push, pop;

  assign in_tready = !stat.full;
  assign take      = in_tvalid & in_tready;

  ffrp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .in_byte     (in_tdata),
    .in_last     (in_tlast),
    .push        (push),
    .push_res    (push_res)
  );

  ffrp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_res),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  ffrp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the sequence record parser: directed opening, random records
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ffrp_pkg::*;

  localparam int ITEMS     = 2000;
  localparam int DIR_LEN   = 21;
  localparam int MARK_ROW  = 2;
  localparam int CALM_FROM = 700;
  localparam int CALM_TO   = 1100;

  typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_TYPED} check_t;
  typedef enum logic [1:0] {RUN_NORMAL, RUN_BAD_MARKER, RUN_EMPTY} run_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
    check_t     check;
    result_t    typed;
  } text_word_t;

  // two blank lines, the first marker, a header, a sequence, a plus and a quality line
  localparam logic [7:0] DIR_TEXT [DIR_LEN] = '{
    CH_LF, CH_LF, CH_GT, "i", "d", CH_SPACE, "x", CH_TAB, CH_CR, CH_LF,
    "A", 8'h00, 8'hFF, CH_SPACE, "T", CH_LF, CH_PLUS, CH_LF, "!", "~", CH_LF
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = 2'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  // side info that travels with the word on the input bus
  check_t      cur_check = CHK_MODEL;
  result_t     cur_typed = '0;
  logic        no_idle = 1'b0;

  text_word_t  byte_stream [$];
  result_t     pending_results [$];
  int          mismatch_cnt = 0;
  int          words_checked = 0;
  fmt_t        last_fmt = FMT_FASTA;
  err_t        last_err = ERR_NONE;

  // parser shadow state
  mode_t       cfg_mode = MODE_DETECT;
  fmt_t        cur_fmt = FMT_FASTA;
  bit          fmt_fixed = 1'b0;
  bit          line_fresh = 1'b1;
  role_t       fq_role = ROLE_HEADER;
  bit          ident_open = 1'b0;
  err_t        held_err = ERR_NONE;
  logic [LINE_COUNT_BITS-1:0] line_no = '0;
  kind_t       line_type = KIND_NONE;
  bit          stream_closed = 1'b0;

  result_t     seen, want, predicted;
  bit          produced;

  mode_t       run_mode;
  fmt_t        run_fmt;
  run_t        run_kind;
  logic [7:0]  marker;
  result_t     opener;
  int          dir_count;
  int          pick;
  int          tail;

  fasta_fastq_record_parser u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 20);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (mismatch_cnt < 50)
      $display("mismatch at result word %0d: %s got %0h expected %0h",
               words_checked, what, got, exp_val);
    mismatch_cnt++;
  endtask

  function automatic void close_line();
    if (cur_fmt == FMT_FASTQ && held_err == ERR_NONE)
      fq_role = role_t'(fq_role + 2'd1);
    ident_open = 1'b0;
    line_type = KIND_NONE;
  endfunction

  // advances the shadow parser by one byte; returns 1 when a result word is due
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output result_t r);
    bit had_err, emit, lead_byte, opens, first_line;
    r = '0;
    emit = 1'b0;
    if (stream_closed) return 1'b0;
    had_err = (held_err != ERR_NONE);
    if (!had_err) begin
      if (line_fresh && line_no != LINE_CNT_MAX) line_no++;
      if (b == CH_LF) begin
        if (!line_fresh) close_line();
        line_fresh = 1'b1;
      end else begin
        lead_byte = line_fresh;
        opens = 1'b0;
        first_line = 1'b0;
        if (lead_byte) begin
          line_fresh = 1'b0;
          if (!fmt_fixed) begin
            // the mode is taken once, at the first non-empty line
            fmt_fixed = 1'b1;
            first_line = 1'b1;
            fq_role = ROLE_HEADER;
            case (cfg_mode)
              MODE_DETECT: begin
                cur_fmt = (b == CH_GT) ? FMT_FASTA : (b == CH_AT) ? FMT_FASTQ : FMT_BARE;
              end
              MODE_FASTA: begin
                cur_fmt = FMT_FASTA;
                if (b != CH_GT) held_err = ERR_BAD_MARKER;
              end
              MODE_FASTQ: begin
                cur_fmt = FMT_FASTQ;
                if (b != CH_AT) held_err = ERR_BAD_MARKER;
              end
              default: cur_fmt = FMT_BARE;
            endcase
          end
          if (held_err == ERR_NONE) begin
            case (cur_fmt)
              FMT_FASTA: begin
                if (b == CH_GT) begin
                  line_type = KIND_HEADER;
                  opens = 1'b1;
                end else begin
                  line_type = KIND_SEQ;
                end
              end
              FMT_FASTQ: begin
                case (fq_role)
                  ROLE_HEADER: begin
                    if (b == CH_AT) begin
                      line_type = KIND_HEADER;
                      opens = 1'b1;
                    end else begin
                      held_err = ERR_BAD_HEADER;
                    end
                  end
                  ROLE_SEQ: line_type = KIND_SEQ;
                  ROLE_PLUS: begin
                    if (b == CH_PLUS) line_type = KIND_DROP;
                    else held_err = ERR_NO_PLUS;
                  end
                  default: line_type = KIND_DROP;
                endcase
              end
              default: begin
                line_type = first_line ? KIND_SEQ : KIND_STRIP;
                opens = first_line;
              end
            endcase
          end
        end
        if (held_err == ERR_NONE) begin
          case (line_type)
            KIND_HEADER: begin
              r.data_valid = 1'b1;
              r.is_header = 1'b1;
              if (lead_byte) begin
                ident_open = 1'b1;
              end else if (ident_open) begin
                if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) ident_open = 1'b0;
                else r.in_identifier = 1'b1;
              end
            end
            KIND_SEQ: r.data_valid = 1'b1;
            KIND_STRIP: r.data_valid = (b != CH_SPACE);
            default: ;
          endcase
          if (r.data_valid) begin
            r.char_out = b;
            r.record_start = opens;
            emit = 1'b1;
          end
        end
      end
    end
    if (last) begin
      if (held_err == ERR_NONE && !line_fresh) close_line();
      line_fresh = 1'b1;
      // a fastq record cut short reports what it was still waiting for
      if (held_err == ERR_NONE && fmt_fixed && cur_fmt == FMT_FASTQ) begin
        case (fq_role)
          ROLE_SEQ:  held_err = ERR_NO_SEQ;
          ROLE_PLUS: held_err = ERR_NO_PLUS;
          ROLE_QUAL: held_err = ERR_NO_QUAL;
          default: ;
        endcase
      end
      stream_closed = 1'b1;
      emit = 1'b1;
    end
    if (!had_err && held_err != ERR_NONE) emit = 1'b1;
    r.stream_end = last;
    r.format_found = cur_fmt;
    r.error_code = held_err;
    r.error_line = (held_err != ERR_NONE) ? line_no[ERR_LINE_BITS-1:0] : '0;
    return emit;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) cfg_mode = mode_t'(cfg_wr_data);
      if (out_tvalid && out_tready) begin
        seen.char_out      = out_tdata[7:0];
        seen.format_found  = fmt_t'(out_tdata[9:8]);
        seen.error_code    = err_t'(out_tdata[12:10]);
        seen.error_line    = out_tdata[36:13];
        seen.data_valid    = out_tuser[0];
        seen.is_header     = out_tuser[1];
        seen.in_identifier = out_tuser[2];
        seen.record_start  = out_tuser[3];
        seen.stream_end    = out_tlast;
        if (pending_results.size() == 0) begin
          report_mismatch("word with none expected", out_tdata[31:0], 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (seen.data_valid !== want.data_valid)
            report_mismatch("data_valid", 32'(seen.data_valid), 32'(want.data_valid));
          if (seen.char_out !== want.char_out)
            report_mismatch("char_out", 32'(seen.char_out), 32'(want.char_out));
          if (seen.is_header !== want.is_header)
            report_mismatch("is_header", 32'(seen.is_header), 32'(want.is_header));
          if (seen.in_identifier !== want.in_identifier)
            report_mismatch("in_identifier", 32'(seen.in_identifier),
                            32'(want.in_identifier));
          if (seen.record_start !== want.record_start)
            report_mismatch("record_start", 32'(seen.record_start), 32'(want.record_start));
          if (seen.stream_end !== want.stream_end)
            report_mismatch("stream_end", 32'(seen.stream_end), 32'(want.stream_end));
          if (seen.format_found !== want.format_found)
            report_mismatch("format_found", 32'(seen.format_found), 32'(want.format_found));
          if (seen.error_code !== want.error_code)
            report_mismatch("error_code", 32'(seen.error_code), 32'(want.error_code));
          if (seen.error_line !== want.error_line)
            report_mismatch("error_line", 32'(seen.error_line), 32'(want.error_line));
        end
        words_checked++;
        last_fmt = seen.format_found;
        last_err = seen.error_code;
      end
      if (in_tvalid && in_tready) begin
        produced = parse_byte(in_tdata, in_tlast, predicted);
        case (cur_check)
          CHK_TYPED: pending_results.push_back(cur_typed);
          CHK_MODEL: if (produced) pending_results.push_back(predicted);
          default: ;
        endcase
      end
    end
  end

  function automatic logic [7:0] any_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == CH_LF);
    return v;
  endfunction

  function automatic logic [7:0] base_char(input int wild_pct);
    if ($urandom_range(0, 99) < wild_pct) return any_byte();
    case ($urandom_range(0, 3))
      0: return "A";
      1: return "C";
      2: return "G";
      default: return "T";
    endcase
  endfunction

  task automatic push_row(input logic [7:0] value, input logic last, input check_t check,
                          input result_t typed);
    text_word_t w;
    w.value = value;
    w.last = last;
    w.check = check;
    w.typed = typed;
    byte_stream.push_back(w);
  endtask

  task automatic push_byte(input logic [7:0] value);
    push_row(value, 1'b0, CHK_MODEL, '0);
  endtask

  task automatic close_stream();
    text_word_t w;
    w = byte_stream.pop_back();
    w.last = 1'b1;
    byte_stream.push_back(w);
  endtask

  task automatic maybe_blank();
    if ($urandom_range(0, 9) == 0) push_byte(CH_LF);
  endtask

  task automatic add_line(input logic [7:0] lead, input bit use_lead, input int len,
                          input int wild_pct);
    if (use_lead) push_byte(lead);
    repeat (len) push_byte(($urandom_range(0, 99) < 8) ? CH_SPACE : base_char(wild_pct));
    push_byte(CH_LF);
  endtask

  // the first n lines of a fastq record
  task automatic add_fastq(input int n);
    if (n > 0) add_line(CH_AT, 1'b1, $urandom_range(1, 12), 20);
    maybe_blank();
    if (n > 1) add_line(CH_LF, 1'b0, $urandom_range(1, 30), 10);
    maybe_blank();
    if (n > 2) add_line(CH_PLUS, 1'b1, $urandom_range(0, 4), 10);
    maybe_blank();
    if (n > 3) add_line(CH_LF, 1'b0, $urandom_range(1, 30), 100);
  endtask

  task automatic add_record(input fmt_t f);
    case (f)
      FMT_FASTA: begin
        add_line(CH_GT, 1'b1, $urandom_range(0, 12), 20);
        repeat ($urandom_range(1, 3)) begin
          maybe_blank();
          add_line(CH_LF, 1'b0, $urandom_range(0, 40), 5);
        end
      end
      FMT_FASTQ: add_fastq(4);
      default: begin
        maybe_blank();
        add_line(CH_LF, 1'b0, $urandom_range(0, 40), 15);
      end
    endcase
  endtask

  task automatic add_noise(input int n, input bit rand_last);
    repeat (n)
      push_row(($urandom_range(0, 5) == 0) ? CH_LF : any_byte(),
               rand_last ? 1'($urandom_range(0, 1)) : 1'b0, CHK_MODEL, '0);
  endtask

  task automatic write_mode(input mode_t m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(input text_word_t w, input bit calm);
    no_idle <= calm;
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w.value;
    in_tlast <= w.last;
    cur_check <= w.check;
    cur_typed <= w.typed;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    for (int n = 0; n < 20000 && pending_results.size() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    run_mode = mode_t'($urandom_range(0, 3));
    case (run_mode)
      MODE_FASTA: run_fmt = FMT_FASTA;
      MODE_FASTQ: run_fmt = FMT_FASTQ;
      MODE_BARE:  run_fmt = FMT_BARE;
      default:    run_fmt = fmt_t'($urandom_range(0, 2));
    endcase
    pick = $urandom_range(0, 15);
    run_kind = RUN_NORMAL;
    if (pick == 0) run_kind = RUN_EMPTY;
    else if (pick == 1 && (run_mode == MODE_FASTA || run_mode == MODE_FASTQ))
      run_kind = RUN_BAD_MARKER;
    case (run_fmt)
      FMT_FASTA: marker = CH_GT;
      FMT_FASTQ: marker = CH_AT;
      default:   marker = (run_mode == MODE_BARE) ? CH_GT : "N";
    endcase

    opener = '0;
    case (run_kind)
      RUN_BAD_MARKER: begin
        marker = "N";
        opener.format_found = run_fmt;
        opener.error_code = ERR_BAD_MARKER;
        opener.error_line = 24'd3;
      end
      RUN_EMPTY: opener.stream_end = 1'b1;
      default: begin
        opener.data_valid = 1'b1;
        opener.char_out = marker;
        opener.is_header = (run_fmt != FMT_BARE);
        opener.record_start = 1'b1;
        opener.format_found = run_fmt;
      end
    endcase

    for (int i = 0; i < ((run_kind == RUN_EMPTY) ? MARK_ROW : DIR_LEN); i++) begin
      if (i < MARK_ROW) push_row(DIR_TEXT[i], 1'b0, CHK_QUIET, '0);
      else if (i == MARK_ROW) push_row(marker, 1'b0, CHK_TYPED, opener);
      else push_byte(DIR_TEXT[i]);
    end
    if (run_kind == RUN_EMPTY) push_row(CH_LF, 1'b1, CHK_TYPED, opener);
    dir_count = byte_stream.size();

    if (run_kind != RUN_EMPTY) begin
      while (byte_stream.size() < dir_count + ITEMS) add_record(run_fmt);
      tail = $urandom_range(0, 7);
      if (run_fmt == FMT_FASTQ && tail >= 4 && tail <= 6) begin
        // record cut after its header, sequence or plus line
        add_fastq(tail - 3);
        if ($urandom_range(0, 1) && byte_stream[byte_stream.size() - 1].value == CH_LF)
          void'(byte_stream.pop_back());
      end else if (run_fmt == FMT_FASTQ && tail == 7) begin
        if ($urandom_range(0, 1)) begin
          add_line("N", 1'b1, 5, 20);
        end else begin
          add_fastq(2);
          add_line("N", 1'b1, 3, 20);
        end
        add_noise(60, 1'b0);
      end else if (tail >= 4) begin
        add_noise(60, 1'b0);
      end else if ($urandom_range(0, 1)) begin
        void'(byte_stream.pop_back());
      end
      close_stream();
    end
    // bytes after the end of input are ignored by the block
    add_noise((run_kind == RUN_EMPTY) ? ITEMS : 20, 1'b1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mode(MODE_BARE);
    write_mode(MODE_DETECT);
    write_mode(run_mode);

    for (int i = 0; i < dir_count; i++) send_word(byte_stream[i], 1'b0);
    in_tvalid <= 1'b0;
    wait_drained();
    // the mode is already fixed or the stream has ended, so this write must change nothing
    write_mode(mode_t'($urandom_range(0, 3)));

    for (int i = dir_count; i < byte_stream.size(); i++)
      send_word(byte_stream[i], (i >= dir_count + CALM_FROM) && (i < dir_count + CALM_TO));
    in_tvalid <= 1'b0;
    wait_drained();
    if (pending_results.size() != 0)
      report_mismatch("result words never seen", pending_results.size(), 32'd0);

    $display("sent %0d bytes in mode %s, %0d result words checked, %0d mismatches",
             byte_stream.size(), run_mode.name(), words_checked, mismatch_cnt);
    $display("last word reported format %s and error %s", last_fmt.name(), last_err.name());
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ffrp_pkg.sv
hw/rtl/ffrp_front.sv
hw/rtl/ffrp_queue.sv
hw/rtl/ffrp_back.sv
hw/rtl/fasta_fastq_record_parser.sv
tb/tb_top.sv
